FILE: design/slui_pkg.sv
// shared types and constants for the sorted list union and intersection block
`timescale 1ns / 1ps

package slui_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int CNT_MAX   = 31;

    localparam logic [CFG_IDX_W-1:0] REG_SET_OP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CNT_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CNT_SEC   = 2'd2;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd5;

    typedef enum logic [1:0] {
        S_LOAD,
        S_FETCH,
        S_STEP,
        S_FLUSH
    } t_state;

endpackage

FILE: design/slui_ram.sv
// one-write one-read list store with registered read data
`timescale 1ns / 1ps

module slui_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/sorted_list_union_intersection.sv
// top level: list loading, two-index merge sequencer and result register
//
// Input stream (s_axis): one signed 32-bit element per request, count_first
// elements of list A followed by count_second elements of list B, each list
// sorted ascending. During loading tready is held high.
// After the last B element tready drops and the merge runs: each step reads
// both list heads from the stores (S_FETCH), then compares them as signed
// values (S_STEP), at most count_first + count_second steps, then a last
// fetch and compare that finds the lists done and a flush state that closes
// the run before tready returns.
// Output stream (m_axis): one result value per request, tlast on the last of
// the run; an empty result is one request with tuser set and tdata zero.
// The result register lets the merge run ahead by one item; when the
// receiver stalls, the merge waits in its compare step until space frees.
// Config writes (cfg channel, always ready) are for the user to make while idle;
// the block does not enforce that. A count write restarts loading at list A.
// Reset (synchronous, active low) restores the register defaults
// (intersection, both counts 5), clears the load count and the output.
// List stores are not cleared.
`timescale 1ns / 1ps

module sorted_list_union_intersection #(
    parameter int MAX_LEN = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [slui_pkg::DATA_W-1:0]      i_s_axis_tdata,   // [31:0] value
    // master stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [slui_pkg::DATA_W-1:0]      o_m_axis_tdata,   // [31:0] result_value
    output logic                             o_m_axis_tlast,   // is_final
    output logic                             o_m_axis_tuser,   // [0] is_empty
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slui_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slui_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    import slui_pkg::*;

    localparam int CLAMP = (MAX_LEN < CNT_MAX) ? MAX_LEN : CNT_MAX;
    localparam int PW    = $clog2(CLAMP + 1);
    localparam int LW    = $clog2(2 * CLAMP + 1);
    localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state r_state, n_state;

    logic             r_set_op;
    logic [CNT_W-1:0] r_cnt_a, r_cnt_b;
    logic [LW-1:0]    r_loaded;
    logic [PW-1:0]    r_i, r_j;
    logic [PW-1:0]    na, nb;

    logic [DATA_W-1:0] r_pend;
    logic              r_pend_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_valid, r_out_last, r_out_empty;

    logic [DATA_W-1:0] rd_a, rd_b;

    // load path
    logic          in_acc, cfg_acc, cnt_write;
    logic [LW-1:0] total, base, base_b, next_loaded;
    logic          wr_a, wr_b, load_done;

    // merge step decisions
    logic              out_free;
    logic              in_main, tail_b, tail_a, step_done;
    logic              emit, adv_i, adv_j, stall;
    logic [DATA_W-1:0] emit_val;
    logic              push;
    logic [DATA_W-1:0] push_data;
    logic              push_last, push_empty;

    always_comb begin
        if (r_cnt_a == '0) begin
            na = PW'(1);
        end else if (int'(r_cnt_a) > CLAMP) begin
            na = PW'(CLAMP);
        end else begin
            na = PW'(r_cnt_a);
        end
        if (r_cnt_b == '0) begin
            nb = PW'(1);
        end else if (int'(r_cnt_b) > CLAMP) begin
            nb = PW'(CLAMP);
        end else begin
            nb = PW'(r_cnt_b);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign cnt_write   = cfg_acc &&
                         (i_cfg_index == REG_CNT_FIRST || i_cfg_index == REG_CNT_SEC);

    assign in_acc      = i_s_axis_tvalid & o_s_axis_tready;
    assign total       = LW'(na) + LW'(nb);
    assign base        = (r_loaded >= total) ? '0 : r_loaded;
    assign wr_a        = in_acc && (base < LW'(na));
    assign wr_b        = in_acc && (base >= LW'(na));
    assign base_b      = base - LW'(na);
    assign next_loaded = base + LW'(1);
    assign load_done   = in_acc && (next_loaded >= total);

    slui_ram #(.DEPTH(MAX_LEN), .WIDTH(DATA_W), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_a),
        .i_waddr (AW'(base)),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (AW'(r_i)),
        .o_rdata (rd_a)
    );

    slui_ram #(.DEPTH(MAX_LEN), .WIDTH(DATA_W), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_b),
        .i_waddr (AW'(base_b)),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (AW'(r_j)),
        .o_rdata (rd_b)
    );

    assign out_free = !r_out_valid || i_m_axis_tready;

    // one compare per step on the two registered heads
    always_comb begin
        in_main   = (r_i < na) && (r_j < nb);
        tail_b    = !in_main && r_set_op && (r_j < nb);
        tail_a    = !in_main && r_set_op && !tail_b && (r_i < na);
        step_done = !in_main && !tail_b && !tail_a;
        emit      = 1'b0;
        adv_i     = 1'b0;
        adv_j     = 1'b0;
        emit_val  = rd_a;
        if (in_main) begin
            if ($signed(rd_a) < $signed(rd_b)) begin
                emit  = r_set_op;
                adv_i = 1'b1;
            end else if ($signed(rd_a) > $signed(rd_b)) begin
                emit     = r_set_op;
                emit_val = rd_b;
                adv_j    = 1'b1;
            end else begin
                emit  = 1'b1;
                adv_i = 1'b1;
                adv_j = 1'b1;
            end
        end else if (tail_b) begin
            emit     = 1'b1;
            emit_val = rd_b;
            adv_j    = 1'b1;
        end else if (tail_a) begin
            emit  = 1'b1;
            adv_i = 1'b1;
        end
        // a new result pushes the held one out, which needs a free slot
        stall = (r_state == S_STEP) && emit && r_pend_valid && !out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (load_done && !cnt_write) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (step_done) begin
                    n_state = S_FLUSH;
                end else if (!stall) begin
                    n_state = S_FETCH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        push            = 1'b0;
        push_data       = r_pend;
        push_last       = 1'b0;
        push_empty      = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_s_axis_tready = 1'b1;
            end
            S_STEP: begin
                push = !step_done && emit && r_pend_valid && out_free;
            end
            S_FLUSH: begin
                push       = out_free;
                push_last  = 1'b1;
                push_empty = !r_pend_valid;
                push_data  = r_pend_valid ? r_pend : '0;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_set_op     <= 1'b0;
            r_cnt_a      <= CNT_RESET;
            r_cnt_b      <= CNT_RESET;
            r_loaded     <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
            r_out_empty  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_acc) begin
                case (i_cfg_index)
                    REG_SET_OP:    r_set_op <= i_cfg_data[0];
                    REG_CNT_FIRST: r_cnt_a  <= i_cfg_data;
                    REG_CNT_SEC:   r_cnt_b  <= i_cfg_data;
                    default:       r_set_op <= r_set_op;
                endcase
            end

            if (cnt_write || load_done) begin
                r_loaded <= '0;
            end else if (in_acc) begin
                r_loaded <= next_loaded;
            end

            if (r_state == S_LOAD) begin
                r_i <= '0;
                r_j <= '0;
            end else if (r_state == S_STEP && !step_done && !stall) begin
                if (adv_i) begin
                    r_i <= r_i + PW'(1);
                end
                if (adv_j) begin
                    r_j <= r_j + PW'(1);
                end
            end

            if (r_state == S_STEP && !step_done && !stall && emit) begin
                r_pend_valid <= 1'b1;
            end else if (r_state == S_FLUSH && out_free) begin
                r_pend_valid <= 1'b0;
            end

            if (push) begin
                r_out_valid <= 1'b1;
                r_out_last  <= push_last;
                r_out_empty <= push_empty;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_STEP && !step_done && !stall && emit) begin
            r_pend <= emit_val;
        end
        if (push) begin
            r_out_data <= push_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_empty;

    // an empty result is always the closing item of its run
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_empty |-> r_out_last)
        else $error("empty result without tlast");

    // merge indices never pass the list lengths
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> (r_i <= na) && (r_j <= nb))
        else $error("merge index out of range");

    // closing a run with room in the output returns to loading
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) && out_free |=> (r_state == S_LOAD) && !r_pend_valid)
        else $error("run did not close");

    // a stalled step keeps its indices
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> $stable(r_i) && $stable(r_j))
        else $error("indices moved during stall");

endmodule
